// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== hdl/i2p_pkg.sv =====
// Types and token codes of the infix-to-postfix converter.
// Depends on nothing; used by the stack cells, the stack and the top level.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

   localparam int RefFieldW = 16;

   // input token kinds
   localparam logic [2:0] TK_OPERAND = 3'd0;
   localparam logic [2:0] TK_OPERATOR = 3'd1;
   localparam logic [2:0] TK_LPAREN = 3'd2;
   localparam logic [2:0] TK_RPAREN = 3'd3;
   localparam logic [2:0] TK_COMMA = 3'd4;
   localparam logic [2:0] TK_CALL_NAME = 3'd5;

   // result kinds
   localparam logic [2:0] OK_OPERAND = 3'd0;
   localparam logic [2:0] OK_OPERATOR = 3'd1;
   localparam logic [2:0] OK_CALL = 3'd2;
   localparam logic [2:0] OK_END = 3'd3;
   localparam logic [2:0] OK_ERROR = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_PAREN = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   localparam logic [3:0] CommaMax = 4'd15;

   // one stack entry without its reference
   typedef struct packed {
      logic       valid;
      logic       is_op;   // 1 operator, 0 left paren
      logic [1:0] code;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_cmd_type;

   // multiply and divide bind tighter than plus and minus
   function automatic logic op_prio_hi(input logic [1:0] code);
      return code[1];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/i2p_cell.sv =====
// One operator stack cell: holds one entry and shifts with its neighbors.
// Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_cell #(
   parameter int REF_BITS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  i2p_pkg::stack_cmd_type  cmd,
   input  i2p_pkg::entry_type      above_entry,
   input  wire [REF_BITS-1:0]      above_ref,
   input  i2p_pkg::entry_type      below_entry,
   input  wire [REF_BITS-1:0]      below_ref,
   output i2p_pkg::entry_type      entry_ff,
   output logic [REF_BITS-1:0]     ref_ff
);
   import i2p_pkg::*;

   // push moves entries away from the top, pop moves them toward it
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (cmd.push) begin
         entry_ff <= above_entry;
      end else if (cmd.pop) begin
         entry_ff <= below_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         ref_ff <= above_ref;
      end else if (cmd.pop) begin
         ref_ff <= below_ref;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/i2p_stack.sv =====
// Operator stack built as a chain of shift cells; cell 0 is the top.
// Depends on i2p_pkg, i2p_cell and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module i2p_stack #(
   parameter int DEPTH    = 16,
   parameter int REF_BITS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  i2p_pkg::stack_cmd_type  cmd,
   input  i2p_pkg::entry_type      push_entry,
   input  wire [REF_BITS-1:0]      push_ref,
   output i2p_pkg::entry_type      top_entry,
   output logic [REF_BITS-1:0]     top_ref,
   output i2p_pkg::entry_type      second_entry,
   output logic                    full
);
   import i2p_pkg::*;

   entry_type             cell_entry [DEPTH];
   logic [REF_BITS-1:0]   cell_ref   [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type           above_e;
      logic [REF_BITS-1:0] above_r;
      entry_type           below_e;
      logic [REF_BITS-1:0] below_r;

      if (i == 0) begin : g_head
         assign above_e = push_entry;
         assign above_r = push_ref;
      end else begin : g_link_up
         assign above_e = cell_entry[i-1];
         assign above_r = cell_ref[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign below_e = '0;
         assign below_r = '0;
      end else begin : g_link_down
         assign below_e = cell_entry[i+1];
         assign below_r = cell_ref[i+1];
      end

      i2p_cell #(
         .REF_BITS (REF_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .above_entry (above_e),
         .above_ref   (above_r),
         .below_entry (below_e),
         .below_ref   (below_r),
         .entry_ff    (cell_entry[i]),
         .ref_ff      (cell_ref[i])
      );
   end

   assign top_entry    = cell_entry[0];
   assign top_ref      = cell_ref[0];
   assign second_entry = cell_entry[1];
   assign full         = cell_entry[DEPTH-1].valid;

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_push_pop_excl, clock, reset, !(cmd.push && cmd.pop))
   `ASSERT_IMPLIES(a_no_push_full, clock, reset, cmd.push, !full)
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, cmd.pop, cell_entry[0].valid)
   `ASSERT_IMPLIES(a_packed_top, clock, reset, cell_entry[1].valid, cell_entry[0].valid)

endmodule

`default_nettype wire

// ===== hdl/infix_to_postfix_converter.sv =====
// Infix-to-postfix token converter (shunting-yard), top level and sequencer.
// Depends on i2p_pkg, i2p_stack (chain of i2p_cell) and assert_macros.svh.
//
//  Channel | Direction | Beat contents
//  --------+-----------+-----------------------------------------------------
//  req_*   | in        | one infix token; tlast = end of expression
//  rsp_*   | out       | one postfix token, call, end marker or error
//
// An accepted token is latched, then handled in the work state; each entry popped
// ahead of the final step takes a step of its own, and an end of expression
// flushes every stack entry before its end marker.
// The result register takes a new beat in the cycle the old one is taken; while
// a beat waits unaccepted the sequencer holds, even for steps that issue none.
// Reset (synchronous, active high) empties the stack and clears call state.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 16,
   parameter int REF_WIDTH   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [1:0] op_code, [17:2] token_ref, rest zero
   input  wire  [2:0]  req_tuser,   // [2:0] token_kind
   input  wire         req_tlast,   // end_of_expr
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] out_op_code, [17:2] out_ref,
                                    // [22:18] param_count, [24:23] error_code
   output logic [2:0]  rsp_tuser,   // [2:0] out_kind
   output logic        rsp_tlast    // last
);
   import i2p_pkg::*;

   localparam int RefBits = (REF_WIDTH < RefFieldW) ? REF_WIDTH : RefFieldW;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   // sequencer and latched token
   logic               state_ff, state_in;
   logic [2:0]         tok_kind_ff;
   logic [1:0]         tok_code_ff;
   logic [RefBits-1:0] tok_ref_ff;
   logic               tok_eoe_ff;
   logic               bad_ff, bad_in;

   // call tracking
   logic               in_call_ff, in_call_in;
   logic               drop_ff, drop_in;
   logic [3:0]         comma_ff, comma_in;
   logic [RefBits-1:0] call_ref_ff, call_ref_in;

   // result register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_kind_ff;
   logic [1:0]         rsp_code_ff;
   logic [RefBits-1:0] rsp_ref_ff;
   logic [4:0]         rsp_pcount_ff;
   logic [1:0]         rsp_err_ff;
   logic               rsp_last_ff;

   // step outputs
   logic               emit;
   logic [2:0]         e_kind;
   logic [1:0]         e_code;
   logic [RefBits-1:0] e_ref;
   logic [4:0]         e_pcount;
   logic [1:0]         e_err;
   logic               e_last;
   logic               done;

   stack_cmd_type      cmd;
   entry_type          push_entry;
   entry_type          top_entry;
   entry_type          second_entry;
   logic [RefBits-1:0] top_ref;
   logic               full;

   logic               accept;
   logic               out_free;
   logic               step;
   logic               pop_cont;
   logic               next_cont;

   i2p_stack #(
      .DEPTH    (STACK_DEPTH),
      .REF_BITS (RefBits)
   ) u_stack (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .push_entry   (push_entry),
      .push_ref     (tok_ref_ff),
      .top_entry    (top_entry),
      .top_ref      (top_ref),
      .second_entry (second_entry),
      .full         (full)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = (state_ff == ST_WORK) && out_free;

   // operator pops: stacked operator of equal or higher priority goes first
   assign pop_cont  = top_entry.valid && top_entry.is_op &&
                      (op_prio_hi(top_entry.code) >= op_prio_hi(tok_code_ff));
   assign next_cont = second_entry.valid && second_entry.is_op &&
                      (op_prio_hi(second_entry.code) >= op_prio_hi(tok_code_ff));

   always_comb begin
      push_entry.valid = 1'b1;
      push_entry.is_op = (tok_kind_ff == TK_OPERATOR);
      push_entry.code  = (tok_kind_ff == TK_OPERATOR) ? tok_code_ff : 2'd0;
   end

   always_comb begin
      emit        = 1'b0;
      e_kind      = OK_OPERAND;
      e_code      = 2'd0;
      e_ref       = '0;
      e_pcount    = 5'd0;
      e_err       = ERR_NONE;
      e_last      = 1'b1;
      done        = 1'b0;
      cmd         = '0;
      bad_in      = bad_ff;
      in_call_in  = in_call_ff;
      drop_in     = drop_ff;
      comma_in    = comma_ff;
      call_ref_in = call_ref_ff;

      if (step) begin
         if (tok_eoe_ff) begin
            // flush: emit operators top first, drop parens, then the marker
            if (top_entry.valid) begin
               cmd.pop = 1'b1;
               if (top_entry.is_op) begin
                  emit   = 1'b1;
                  e_kind = OK_OPERATOR;
                  e_code = top_entry.code;
                  e_ref  = top_ref;
                  e_last = 1'b0;
               end else begin
                  bad_in = 1'b1;
               end
            end else begin
               emit        = 1'b1;
               e_kind      = OK_END;
               e_err       = (bad_ff || in_call_ff) ? ERR_PAREN : ERR_NONE;
               done        = 1'b1;
               in_call_in  = 1'b0;
               drop_in     = 1'b0;
               comma_in    = '0;
               call_ref_in = '0;
            end
         end else if (in_call_ff) begin
            // inside a call: copy tokens in place
            done    = 1'b1;
            drop_in = 1'b0;
            if (!(drop_ff && (tok_kind_ff == TK_LPAREN))) begin
               case (tok_kind_ff)
                  TK_OPERAND, TK_CALL_NAME: begin
                     emit  = 1'b1;
                     e_ref = tok_ref_ff;
                  end
                  TK_OPERATOR: begin
                     emit   = 1'b1;
                     e_kind = OK_OPERATOR;
                     e_code = tok_code_ff;
                     e_ref  = tok_ref_ff;
                  end
                  TK_COMMA: begin
                     if (comma_ff < CommaMax) begin
                        comma_in = comma_ff + 4'd1;
                     end
                  end
                  TK_RPAREN: begin
                     emit        = 1'b1;
                     e_kind      = OK_CALL;
                     e_ref       = call_ref_ff;
                     e_pcount    = {1'b0, comma_ff} + 5'd1;
                     in_call_in  = 1'b0;
                     comma_in    = '0;
                     call_ref_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end else begin
            case (tok_kind_ff)
               TK_OPERAND: begin
                  emit  = 1'b1;
                  e_ref = tok_ref_ff;
                  done  = 1'b1;
               end
               TK_CALL_NAME: begin
                  emit        = 1'b1;
                  e_ref       = tok_ref_ff;
                  done        = 1'b1;
                  in_call_in  = 1'b1;
                  drop_in     = 1'b1;
                  comma_in    = '0;
                  call_ref_in = tok_ref_ff;
               end
               TK_OPERATOR: begin
                  if (pop_cont) begin
                     // after a pop the stack has room, so the push follows
                     cmd.pop = 1'b1;
                     emit    = 1'b1;
                     e_kind  = OK_OPERATOR;
                     e_code  = top_entry.code;
                     e_ref   = top_ref;
                     e_last  = !next_cont;
                  end else if (full) begin
                     emit   = 1'b1;
                     e_kind = OK_ERROR;
                     e_err  = ERR_OVERFLOW;
                     done   = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                     done     = 1'b1;
                  end
               end
               TK_LPAREN: begin
                  done = 1'b1;
                  if (full) begin
                     emit   = 1'b1;
                     e_kind = OK_ERROR;
                     e_err  = ERR_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               TK_RPAREN: begin
                  if (top_entry.valid) begin
                     cmd.pop = 1'b1;
                     if (top_entry.is_op) begin
                        // last only when the matching paren comes next
                        emit   = 1'b1;
                        e_kind = OK_OPERATOR;
                        e_code = top_entry.code;
                        e_ref  = top_ref;
                        e_last = second_entry.valid && !second_entry.is_op;
                     end else begin
                        done = 1'b1;
                     end
                  end else begin
                     emit   = 1'b1;
                     e_kind = OK_ERROR;
                     e_err  = ERR_PAREN;
                     done   = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bad_ff       <= 1'b0;
         in_call_ff   <= 1'b0;
         drop_ff      <= 1'b0;
         comma_ff     <= '0;
         call_ref_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bad_ff      <= accept ? 1'b0 : bad_in;
         in_call_ff  <= in_call_in;
         drop_ff     <= drop_in;
         comma_ff    <= comma_in;
         call_ref_ff <= call_ref_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // latch the token on accept; mask the reference to its stored width
   always_ff @(posedge clock) begin
      if (accept) begin
         tok_kind_ff <= req_tuser;
         tok_code_ff <= req_tdata[1:0];
         tok_ref_ff  <= req_tdata[2 +: RefBits];
         tok_eoe_ff  <= req_tlast;
      end
   end

   // result payload, loaded only when the slot is free
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff   <= e_kind;
         rsp_code_ff   <= e_code;
         rsp_ref_ff    <= e_ref;
         rsp_pcount_ff <= e_pcount;
         rsp_err_ff    <= e_err;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_err_ff, rsp_pcount_ff,
                        RefFieldW'(rsp_ref_ff), rsp_code_ff};

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_end_is_last, clock, reset, emit && (e_kind == OK_END), e_last)
   `ASSERT_NEXT(a_end_clears, clock, reset, emit && (e_kind == OK_END),
                !top_entry.valid && !in_call_ff && (state_ff == ST_IDLE))
   `ASSERT_IMPLIES(a_idle_no_stack, clock, reset, state_ff == ST_IDLE,
                   !cmd.push && !cmd.pop && !emit)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the infix-to-postfix converter: random and directed token streams.
// Depends on i2p_pkg and infix_to_postfix_converter; the postfix order is predicted
// by the scoreboard class below.
`timescale 1ns / 1ps

import i2p_pkg::*;

localparam int OpStackDepth = 16;

// operator codes on req_tdata[1:0]
localparam logic [1:0] OP_ADD = 2'd0;
localparam logic [1:0] OP_SUB = 2'd1;
localparam logic [1:0] OP_MUL = 2'd2;
localparam logic [1:0] OP_DIV = 2'd3;

// token kinds the block ignores
localparam logic [2:0] TK_RSVD6 = 3'd6;
localparam logic [2:0] TK_RSVD7 = 3'd7;

typedef struct packed {
   logic [2:0]  kind;
   logic [1:0]  op;
   logic [15:0] tref;
   logic [4:0]  pc;
   logic [1:0]  err;
   logic        last;
} postfix_tok_type;

class postfix_scoreboard;
   bit              stk_is_op [OpStackDepth];
   logic [1:0]      stk_code [OpStackDepth];
   logic [15:0]     stk_ref [OpStackDepth];
   int unsigned     depth_used;
   bit              in_call;
   bit              skip_lparen;
   int unsigned     commas;
   logic [15:0]     call_id;
   postfix_tok_type burst[$];
   postfix_tok_type expected_tokens[$];
   int unsigned     failures;

   function void clear_state();
      depth_used  = 0;
      in_call     = 0;
      skip_lparen = 0;
      commas      = 0;
      call_id     = '0;
   endfunction

   function int unsigned rank(logic [1:0] op);
      return op[1] ? 3 : 2;
   endfunction

   function void queue_token(logic [2:0] kind, logic [1:0] op, logic [15:0] tref,
                             logic [4:0] pc, logic [1:0] err);
      postfix_tok_type tok;
      tok = '{kind: kind, op: op, tref: tref, pc: pc, err: err, last: 1'b0};
      burst.push_back(tok);
   endfunction

   // Work out every result beat that one accepted infix token causes.
   function void accept_infix_token(logic [2:0] kind, logic [1:0] op, logic [15:0] tref,
                                    logic eoe);
      bit          leftover;
      bit          found;
      int unsigned t;
      burst.delete();
      if (eoe) begin
         leftover = in_call;
         while (depth_used > 0) begin
            t = depth_used - 1;
            if (stk_is_op[t]) queue_token(OK_OPERATOR, stk_code[t], stk_ref[t], 5'd0, ERR_NONE);
            else leftover = 1;
            depth_used = t;
         end
         queue_token(OK_END, 2'd0, 16'd0, 5'd0, leftover ? ERR_PAREN : ERR_NONE);
         clear_state();
      end else if (in_call && skip_lparen && kind == TK_LPAREN) begin
         skip_lparen = 0;
      end else if (in_call) begin
         skip_lparen = 0;
         case (kind)
            TK_OPERAND, TK_CALL_NAME: queue_token(OK_OPERAND, 2'd0, tref, 5'd0, ERR_NONE);
            TK_OPERATOR: queue_token(OK_OPERATOR, op, tref, 5'd0, ERR_NONE);
            TK_COMMA: if (commas < CommaMax) commas++;
            TK_RPAREN: begin
               queue_token(OK_CALL, 2'd0, call_id, 5'(commas + 1), ERR_NONE);
               in_call = 0;
               commas  = 0;
               call_id = '0;
            end
            default: ;
         endcase
      end else begin
         case (kind)
            TK_OPERAND: queue_token(OK_OPERAND, 2'd0, tref, 5'd0, ERR_NONE);
            TK_CALL_NAME: begin
               queue_token(OK_OPERAND, 2'd0, tref, 5'd0, ERR_NONE);
               in_call     = 1;
               skip_lparen = 1;
               commas      = 0;
               call_id     = tref;
            end
            TK_OPERATOR: begin
               // left-associative: pop everything of equal or higher rank
               while (depth_used > 0) begin
                  t = depth_used - 1;
                  if (!stk_is_op[t] || rank(stk_code[t]) < rank(op)) break;
                  queue_token(OK_OPERATOR, stk_code[t], stk_ref[t], 5'd0, ERR_NONE);
                  depth_used = t;
               end
               if (depth_used >= OpStackDepth) begin
                  queue_token(OK_ERROR, 2'd0, 16'd0, 5'd0, ERR_OVERFLOW);
               end else begin
                  stk_is_op[depth_used] = 1;
                  stk_code[depth_used]  = op;
                  stk_ref[depth_used]   = tref;
                  depth_used++;
               end
            end
            TK_LPAREN: begin
               if (depth_used >= OpStackDepth) begin
                  queue_token(OK_ERROR, 2'd0, 16'd0, 5'd0, ERR_OVERFLOW);
               end else begin
                  stk_is_op[depth_used] = 0;
                  stk_code[depth_used]  = 2'd0;
                  stk_ref[depth_used]   = tref;
                  depth_used++;
               end
            end
            TK_RPAREN: begin
               found = 0;
               while (depth_used > 0 && !found) begin
                  t = depth_used - 1;
                  depth_used = t;
                  if (!stk_is_op[t]) found = 1;
                  else queue_token(OK_OPERATOR, stk_code[t], stk_ref[t], 5'd0, ERR_NONE);
               end
               if (!found) queue_token(OK_ERROR, 2'd0, 16'd0, 5'd0, ERR_PAREN);
            end
            default: ;
         endcase
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) expected_tokens.push_back(burst[i]);
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // Compare one result beat with the oldest expected token.
   function void check_postfix_token(postfix_tok_type got);
      postfix_tok_type want;
      if (expected_tokens.size() == 0) begin
         $error("unexpected result beat: out_kind %0d out_ref %0d", got.kind, got.tref);
         failures++;
         return;
      end
      want = expected_tokens.pop_front();
      check_field("out_kind", want.kind, got.kind);
      check_field("out_op_code", want.op, got.op);
      check_field("out_ref", want.tref, got.tref);
      check_field("param_count", want.pc, got.pc);
      check_field("error_code", want.err, got.err);
      check_field("last", want.last, got.last);
   endfunction
endclass

module tb;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [1:0] op_code, [17:2] token_ref, rest zero
   logic [2:0]  req_tuser  = '0;   // [2:0] token_kind
   logic        req_tlast  = 1'b0; // end_of_expr
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [1:0] op, [17:2] ref, [22:18] param_count, [24:23] error
   logic [2:0]  rsp_tuser;         // [2:0] out_kind
   logic        rsp_tlast;         // last

   postfix_scoreboard sb;
   int unsigned       sender_idle_pct = 0;
   int unsigned       sink_stall_pct  = 0;
   int unsigned       tokens_sent     = 0;

   infix_to_postfix_converter #(
      .STACK_DEPTH(OpStackDepth),
      .REF_WIDTH  (16)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [15:0] rnd_ref();
      return 16'($urandom);
   endfunction

   function automatic logic [1:0] rnd_op();
      return 2'($urandom);
   endfunction

   // Present one token beat and hold it until accepted. Valid stays high after the
   // beat so that a back-to-back token needs no second assignment in the same step.
   task automatic send_token(logic [2:0] kind, logic [1:0] op, logic [15:0] tref, logic eoe);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, tref, op};
      req_tuser  <= kind;
      req_tlast  <= eoe;
      do @(posedge clock); while (!req_tready);
      sb.accept_infix_token(kind, op, tref, eoe);
      if (eoe || kind <= TK_CALL_NAME) tokens_sent++;
   endtask

   // End of expression: the token fields are don't-care, so scramble them.
   task automatic send_end();
      send_token(3'($urandom), rnd_op(), rnd_ref(), 1'b1);
   endtask

   // Call name, argument list and closing paren; a broken call may lose its left paren.
   task automatic send_call(int unsigned args, bit broken);
      int unsigned parts;
      send_token(TK_CALL_NAME, rnd_op(), rnd_ref(), 1'b0);
      if (!broken || $urandom_range(0, 2) != 0) send_token(TK_LPAREN, rnd_op(), rnd_ref(), 1'b0);
      for (int unsigned a = 0; a < args; a++) begin
         if (a > 0) send_token(TK_COMMA, rnd_op(), rnd_ref(), 1'b0);
         parts = $urandom_range(1, 3);
         for (int unsigned p = 0; p < parts; p++) begin
            if (p > 0) send_token(TK_OPERATOR, rnd_op(), rnd_ref(), 1'b0);
            // a stray left paren inside a call is dropped by the block
            if ($urandom_range(0, 7) == 0) send_token(TK_LPAREN, rnd_op(), rnd_ref(), 1'b0);
            send_token(($urandom_range(0, 5) == 0) ? TK_CALL_NAME : TK_OPERAND,
                       rnd_op(), rnd_ref(), 1'b0);
         end
      end
      send_token(TK_RPAREN, rnd_op(), rnd_ref(), 1'b0);
   endtask

   // Well-formed infix expression with random content; a broken one leaves parens
   // open, adds a stray close or drops the paren after a call name.
   task automatic send_expression(bit broken);
      int unsigned terms;
      int unsigned opens;
      terms = $urandom_range(1, 6);
      opens = 0;
      for (int unsigned n = 0; n < terms; n++) begin
         while (opens < 6 && $urandom_range(0, 3) == 0) begin
            send_token(TK_LPAREN, rnd_op(), rnd_ref(), 1'b0);
            opens++;
         end
         if ($urandom_range(0, 4) == 0) send_call($urandom_range(1, 4), broken);
         else send_token(TK_OPERAND, rnd_op(), rnd_ref(), 1'b0);
         while (opens > 0 && $urandom_range(0, 2) == 0) begin
            send_token(TK_RPAREN, rnd_op(), rnd_ref(), 1'b0);
            opens--;
         end
         if (n + 1 < terms) send_token(TK_OPERATOR, rnd_op(), rnd_ref(), 1'b0);
      end
      if (!broken) begin
         while (opens > 0) begin
            send_token(TK_RPAREN, rnd_op(), rnd_ref(), 1'b0);
            opens--;
         end
      end else if ($urandom_range(0, 1) == 1) begin
         send_token(TK_RPAREN, rnd_op(), rnd_ref(), 1'b0);
      end
      send_end();
   endtask

   // Hold the sender until every expected result beat has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Result side: check each accepted beat, then pick the next ready level.
   initial begin
      postfix_tok_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{kind: rsp_tuser, op: rsp_tdata[1:0], tref: rsp_tdata[17:2],
                    pc: rsp_tdata[22:18], err: rsp_tdata[24:23], last: rsp_tlast};
            sb.check_postfix_token(got);
         end
         rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   initial begin
      int unsigned phase_goal;
      int unsigned pick;
      int unsigned nest;
      sb = new;
      sb.clear_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: every operator with priority and left associativity, field extremes
      send_token(TK_OPERAND, OP_ADD, 16'h0000, 1'b0);
      send_token(TK_OPERATOR, OP_ADD, 16'hFFFF, 1'b0);
      send_token(TK_OPERAND, OP_DIV, 16'hFFFF, 1'b0);
      send_token(TK_OPERATOR, OP_MUL, 16'h5555, 1'b0);
      send_token(TK_OPERAND, OP_ADD, 16'hAAAA, 1'b0);
      send_token(TK_OPERATOR, OP_SUB, 16'h0001, 1'b0);
      send_token(TK_OPERAND, OP_ADD, 16'h8000, 1'b0);
      send_token(TK_OPERATOR, OP_DIV, 16'h7FFF, 1'b0);
      send_token(TK_OPERAND, OP_ADD, 16'h1234, 1'b0);
      send_end();
      // Paren pair, right paren with no left paren, left paren left open at the end
      send_token(TK_LPAREN, OP_ADD, 16'h0010, 1'b0);
      send_token(TK_OPERAND, OP_ADD, 16'h0011, 1'b0);
      send_token(TK_RPAREN, OP_ADD, 16'h0012, 1'b0);
      send_token(TK_RPAREN, OP_ADD, 16'h0013, 1'b0);
      send_token(TK_LPAREN, OP_ADD, 16'h0014, 1'b0);
      send_end();
      // Comma outside a call and the reserved kinds: no result at all
      send_token(TK_COMMA, OP_ADD, 16'h0020, 1'b0);
      send_token(TK_RSVD6, OP_MUL, 16'h0021, 1'b0);
      send_token(TK_RSVD7, OP_DIV, 16'h0022, 1'b0);
      // Call with two arguments, then a call name with no left paren after it
      send_token(TK_CALL_NAME, OP_ADD, 16'h0030, 1'b0);
      send_token(TK_LPAREN, OP_ADD, 16'h0031, 1'b0);
      send_token(TK_OPERAND, OP_ADD, 16'h0032, 1'b0);
      send_token(TK_COMMA, OP_ADD, 16'h0033, 1'b0);
      send_token(TK_OPERAND, OP_ADD, 16'h0034, 1'b0);
      send_token(TK_RPAREN, OP_ADD, 16'h0035, 1'b0);
      send_token(TK_CALL_NAME, OP_ADD, 16'h0040, 1'b0);
      send_token(TK_OPERAND, OP_ADD, 16'h0041, 1'b0);
      send_token(TK_RPAREN, OP_ADD, 16'h0042, 1'b0);
      send_end();
      wait_drained();

      // Random phases: free running, idle sender, stalling receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 69; end
            default: begin sender_idle_pct = 32; sink_stall_pct = 32; end
         endcase
         phase_goal = tokens_sent + 88;
         while (tokens_sent < phase_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               send_expression($urandom_range(0, 4) == 0);
            end else if (pick < 82) begin
               // noise: any kind, any field, an occasional end of expression
               repeat ($urandom_range(1, 6))
                  send_token(3'($urandom), rnd_op(), rnd_ref(), $urandom_range(0, 9) == 0);
            end else if (pick < 91) begin
               // long argument list: the comma count may saturate
               send_call($urandom_range(14, 20), 1'b0);
               send_end();
            end else begin
               // deep nesting around the stack limit: may overflow on paren or operator push
               nest = $urandom_range(OpStackDepth - 2, OpStackDepth + 2);
               repeat (nest) send_token(TK_LPAREN, rnd_op(), rnd_ref(), 1'b0);
               send_token(TK_OPERAND, rnd_op(), rnd_ref(), 1'b0);
               send_token(TK_OPERATOR, rnd_op(), rnd_ref(), 1'b0);
               send_token(TK_OPERAND, rnd_op(), rnd_ref(), 1'b0);
               send_end();
            end
         end
         wait_drained();
      end

      // Let a last token that yields nothing finish inside the block, then look for strays.
      repeat (40) @(posedge clock);
      if (sb.expected_tokens.size() != 0) begin
         $error("%0d expected result beats never arrived", sb.expected_tokens.size());
         sb.failures++;
      end
      if (sb.failures == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/i2p_pkg.sv
hdl/i2p_cell.sv
hdl/i2p_stack.sv
hdl/infix_to_postfix_converter.sv
bench/tb.sv
